// ===== rtl/core/parallel_to_spi_master_bridge_core_defines.svh =====
// Assertion macros shared by the checker files.
`ifndef PARALLEL_TO_SPI_MASTER_BRIDGE_CORE_DEFINES_SVH
`define PARALLEL_TO_SPI_MASTER_BRIDGE_CORE_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define P2S_ASSERT_COMB(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define P2S_ASSERT_SEQ(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/p2s_pkg.sv =====
package p2s_pkg;

   localparam int WORD_BITS   = 8;
   localparam int BIT_IDX_W   = $clog2(WORD_BITS);
   localparam int NIBBLE_BITS = 4;

   // Register addresses seen in the low nibble of data_in
   typedef enum logic [NIBBLE_BITS-1:0] {
      REG_CTRL    = 4'd0,
      REG_DIVIDER = 4'd1,
      REG_MODE    = 4'd2,
      REG_COUNT   = 4'd3
   } reg_addr_type;

   typedef struct packed {
      logic                 last_bus_clock;
      logic                 spi_enabled;
      logic                 irq_enabled;
      logic [3:0]           clock_divider;
      logic [1:0]           spi_mode_setting;
      logic [1:0]           bytes_per_transfer;
      logic [WORD_BITS-1:0] tx_byte;
      logic [WORD_BITS-1:0] rx_shift;
      logic [3:0]           bit_counter;
      logic [1:0]           byte_counter;
      logic                 busy;
      logic                 sclk_state;
      logic [3:0]           divider_count;
      logic                 rx_ready;
      logic [WORD_BITS-1:0] out_latch;
      logic                 mosi_state;
      logic                 select_state;
   } state_type;

   localparam state_type STATE_RESET = '{
      last_bus_clock:     1'b0,
      spi_enabled:        1'b1,
      irq_enabled:        1'b0,
      clock_divider:      4'd0,
      spi_mode_setting:   2'd0,
      bytes_per_transfer: 2'd0,
      tx_byte:            '0,
      rx_shift:           '0,
      bit_counter:        4'd0,
      byte_counter:       2'd0,
      busy:               1'b0,
      sclk_state:         1'b0,
      divider_count:      4'd0,
      rx_ready:           1'b0,
      out_latch:          '0,
      mosi_state:         1'b0,
      select_state:       1'b1
   };

   typedef struct packed {
      logic [WORD_BITS-1:0] data_out;
      logic                 sclk_level;
      logic                 mosi_level;
      logic                 spi_select_n;
      logic                 irq;
   } rsp_payload_type;

endpackage

// ===== rtl/core/p2s_req_if.sv =====
interface p2s_req_if;
   logic                          valid;
   logic                          ready;
   logic                          select_n;
   logic                          bus_clock;
   logic                          config_select;
   logic                          strobe_req;
   logic [p2s_pkg::WORD_BITS-1:0] data_in;
   logic                          miso_level;

   modport source (
      output valid, select_n, bus_clock, config_select, strobe_req, data_in, miso_level,
      input  ready
   );
   modport sink (
      input  valid, select_n, bus_clock, config_select, strobe_req, data_in, miso_level,
      output ready
   );
endinterface

// ===== rtl/core/p2s_rsp_if.sv =====
interface p2s_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [p2s_pkg::WORD_BITS-1:0] data_out;
   logic                          sclk_level;
   logic                          mosi_level;
   logic                          spi_select_n;
   logic                          irq;

   modport source (
      output valid, data_out, sclk_level, mosi_level, spi_select_n, irq,
      input  ready
   );
   modport sink (
      input  valid, data_out, sclk_level, mosi_level, spi_select_n, irq,
      output ready
   );
endinterface

// ===== rtl/core/parallel_to_spi_master_bridge_core.sv =====
// SPI master driven by sampled host pins. Every req transfer is one sampled
// tick of the host pins (select_n, bus_clock, config_select, strobe_req,
// data_in, miso_level) and yields exactly one rsp transfer carrying the pin
// levels the bridge drives after that tick (data_out, SCLK, MOSI, SPI slave
// select, irq). A tick is taken in the cycle it is offered whenever the
// two-entry result queue has room, so the sustained rate is one tick per
// cycle; its result, made by one pass of next-state logic on the state
// register, is registered into the queue and offered on rsp behind any
// older results. With select_n high the block only tracks the bus clock
// level. A rising bus clock with config_select high reads or writes one of
// four registers (address in the low nibble, write data in the high nibble):
// 0 enable/irq enable, 1 clock divider, 2 mode (stored only), 3 byte count.
// With config_select low, a strobe while idle starts an MSB-first transfer
// of data_in, repeated per the byte count; the received byte lands on
// data_out when the run ends.
module parallel_to_spi_master_bridge_core (
   input logic         clock,
   input logic         reset,
   p2s_req_if.sink     req_if,
   p2s_rsp_if.source   rsp_if
);

   // Architectural state of the bridge
   p2s_pkg::state_type       state_ff;
   p2s_pkg::state_type       state_in;

   // Two-entry result queue: slot0 is the head
   p2s_pkg::rsp_payload_type slot0_ff, slot0_in;
   p2s_pkg::rsp_payload_type slot1_ff, slot1_in;
   logic [1:0]               count_ff, count_in;
   p2s_pkg::rsp_payload_type result;

   logic push;
   logic pop;

   // Queue has room unless both slots are full; no path from rsp.ready.
   assign req_if.ready = (count_ff != 2'd2);
   assign push         = req_if.valid & req_if.ready;
   assign pop          = rsp_if.valid & rsp_if.ready;

   // ------------------------------------------------------------------
   // Next state for one tick
   // ------------------------------------------------------------------
   always_comb begin
      p2s_pkg::state_type s;
      logic               rise;
      s    = state_ff;
      rise = req_if.bus_clock & ~state_ff.last_bus_clock;

      if (req_if.select_n) begin
         // Host deselected: only follow the bus clock
         s.last_bus_clock = req_if.bus_clock;
      end else begin
         if (rise) begin
            if (req_if.config_select) begin
               if (req_if.strobe_req) begin
                  // Register write, data in the high nibble
                  unique case (req_if.data_in[3:0])
                     p2s_pkg::REG_CTRL: begin
                        s.spi_enabled = req_if.data_in[4];
                        s.irq_enabled = req_if.data_in[5];
                     end
                     p2s_pkg::REG_DIVIDER: s.clock_divider      = req_if.data_in[7:4];
                     p2s_pkg::REG_MODE:    s.spi_mode_setting   = req_if.data_in[5:4];
                     p2s_pkg::REG_COUNT:   s.bytes_per_transfer = req_if.data_in[5:4];
                     default: ;
                  endcase
               end else begin
                  // Register read onto the output latch; unmapped reads as 0
                  unique case (req_if.data_in[3:0])
                     p2s_pkg::REG_CTRL:
                        s.out_latch = {6'd0, state_ff.irq_enabled, state_ff.spi_enabled};
                     p2s_pkg::REG_DIVIDER: s.out_latch = {4'd0, state_ff.clock_divider};
                     p2s_pkg::REG_MODE:    s.out_latch = {6'd0, state_ff.spi_mode_setting};
                     p2s_pkg::REG_COUNT:   s.out_latch = {6'd0, state_ff.bytes_per_transfer};
                     default:              s.out_latch = '0;
                  endcase
               end
            end else if (req_if.strobe_req && !state_ff.busy) begin
               // Start of a transfer; MSB goes out right away
               s.tx_byte       = req_if.data_in;
               s.rx_ready      = 1'b0;
               s.rx_shift      = '0;
               s.bit_counter   = 4'd0;
               s.busy          = 1'b1;
               s.sclk_state    = 1'b0;
               s.divider_count = 4'd0;
               s.select_state  = 1'b0;
               s.mosi_state    = req_if.data_in[p2s_pkg::WORD_BITS-1];
            end
         end
         s.last_bus_clock = req_if.bus_clock;

         if (s.busy && s.spi_enabled) begin
            // Divider prescales the half-period steps; zero steps every tick
            s.divider_count = s.divider_count + 4'd1;
            if (s.divider_count >= s.clock_divider) begin
               s.divider_count = 4'd0;
               if (!s.sclk_state) begin
                  // SCLK rising: sample MISO
                  s.rx_shift   = {s.rx_shift[p2s_pkg::WORD_BITS-2:0], req_if.miso_level};
                  s.sclk_state = 1'b1;
               end else begin
                  // SCLK falling: advance bit, shift out next MOSI
                  s.bit_counter = s.bit_counter + 4'd1;
                  if (s.bit_counter >= 4'(p2s_pkg::WORD_BITS)) begin
                     s.byte_counter = s.byte_counter + 2'd1;
                     if (s.byte_counter >= s.bytes_per_transfer) begin
                        // Run done; SCLK held high until the next idle tick
                        s.busy         = 1'b0;
                        s.rx_ready     = 1'b1;
                        s.out_latch    = s.rx_shift;
                        s.byte_counter = 2'd0;
                        s.bit_counter  = 4'd0;
                     end else begin
                        // Repeat byte: restart from the MSB
                        s.bit_counter = 4'd0;
                        s.mosi_state  = s.tx_byte[p2s_pkg::WORD_BITS-1];
                        s.sclk_state  = 1'b0;
                     end
                  end else begin
                     s.mosi_state = s.tx_byte[p2s_pkg::BIT_IDX_W'(p2s_pkg::WORD_BITS - 1)
                                              - s.bit_counter[p2s_pkg::BIT_IDX_W-1:0]];
                     s.sclk_state = 1'b0;
                  end
               end
            end
         end else if (!s.busy && s.sclk_state) begin
            // Trailing edge after a run: drop SCLK and release the slave
            s.select_state = 1'b1;
            s.sclk_state   = 1'b0;
         end
      end

      state_in = s;
   end

   // Pin levels after this tick
   always_comb begin
      result.data_out     = state_in.out_latch;
      result.sclk_level   = state_in.sclk_state;
      result.mosi_level   = state_in.mosi_state;
      result.spi_select_n = state_in.select_state;
      result.irq          = state_in.rx_ready & state_in.irq_enabled;
   end

   // ------------------------------------------------------------------
   // Result queue control
   // ------------------------------------------------------------------
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      case (count_ff)
         2'd0: begin
            if (push) begin
               slot0_in = result;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            if (push && pop) begin
               slot0_in = result;
            end else if (push) begin
               slot1_in = result;
               count_in = 2'd2;
            end else if (pop) begin
               count_in = 2'd0;
            end
         end
         2'd2: begin
            // No push possible while full
            if (pop) begin
               slot0_in = slot1_ff;
               count_in = 2'd1;
            end
         end
         default: count_in = 2'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= p2s_pkg::STATE_RESET;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            state_ff <= state_in;
         end
         count_ff <= count_in;
      end
   end

   // Payload slots need no reset
   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_if.valid        = (count_ff != 2'd0);
   assign rsp_if.data_out     = slot0_ff.data_out;
   assign rsp_if.sclk_level   = slot0_ff.sclk_level;
   assign rsp_if.mosi_level   = slot0_ff.mosi_level;
   assign rsp_if.spi_select_n = slot0_ff.spi_select_n;
   assign rsp_if.irq          = slot0_ff.irq;

endmodule

// ===== rtl/core/p2s_checker.sv =====
`include "parallel_to_spi_master_bridge_core_defines.svh"

module p2s_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [p2s_pkg::WORD_BITS-1:0] rsp_data_out,
   input logic                          rsp_sclk_level,
   input logic                          rsp_spi_select_n
);

   // Ticks taken but not yet delivered
   logic [2:0] pending_ff, pending_in;

   assign pending_in = pending_ff + 3'(req_valid & req_ready) - 3'(rsp_valid & rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 3'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `P2S_ASSERT_SEQ(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data_out), "rsp dropped or changed while stalled")
   `P2S_ASSERT_COMB(a_no_phantom, !rsp_valid || (pending_ff != 3'd0), "rsp offered with no tick outstanding")
   `P2S_ASSERT_COMB(a_pending_bound, pending_ff <= 3'd2, "more ticks outstanding than queue holds")
   `P2S_ASSERT_COMB(a_idle_sclk_low, !(rsp_valid && rsp_spi_select_n && rsp_sclk_level), "SCLK high while slave deselected")

endmodule

bind parallel_to_spi_master_bridge_core p2s_checker u_p2s_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_data_out     (rsp_if.data_out),
   .rsp_sclk_level   (rsp_if.sclk_level),
   .rsp_spi_select_n (rsp_if.spi_select_n)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// One sampled tick of the host pins
typedef struct packed {
   logic                          select_n;
   logic                          bus_clock;
   logic                          config_select;
   logic                          strobe_req;
   logic [p2s_pkg::WORD_BITS-1:0] data_in;
   logic                          miso_level;
} pin_sample_type;

// Mirrors the bridge registers and serial engine. Each tick yields the pin levels
// expected on the rsp transfer that answers it, in order.
class bridge_tracker;
   p2s_pkg::rsp_payload_type expected_pins[$];
   int                       mismatches;

   bit                          last_bus_clock, spi_enabled, irq_enabled;
   bit                          busy, rx_ready, sclk, mosi, spi_sel_n;
   bit [3:0]                    clock_divider, bit_count, div_count;
   bit [1:0]                    mode_setting, byte_target, byte_count;
   bit [p2s_pkg::WORD_BITS-1:0] tx_byte, rx_shift, out_latch;

   function new();
      spi_enabled = 1'b1;
      spi_sel_n   = 1'b1;
   endfunction

   function int pending();
      return expected_pins.size();
   endfunction

   function void note_tick(pin_sample_type t);
      p2s_pkg::rsp_payload_type want;
      logic [3:0]               addr;
      logic [3:0]               nibble;
      addr   = t.data_in[3:0];
      nibble = t.data_in[7:4];
      if (t.select_n) begin
         last_bus_clock = t.bus_clock;
      end else begin
         if (t.bus_clock && !last_bus_clock) begin
            if (t.config_select) begin
               if (t.strobe_req) begin
                  case (addr)
                     p2s_pkg::REG_CTRL: begin
                        spi_enabled = nibble[0];
                        irq_enabled = nibble[1];
                     end
                     p2s_pkg::REG_DIVIDER: clock_divider = nibble;
                     p2s_pkg::REG_MODE:    mode_setting  = nibble[1:0];
                     p2s_pkg::REG_COUNT:   byte_target   = nibble[1:0];
                     default: ;
                  endcase
               end else begin
                  case (addr)
                     p2s_pkg::REG_CTRL:    out_latch = {6'd0, irq_enabled, spi_enabled};
                     p2s_pkg::REG_DIVIDER: out_latch = {4'd0, clock_divider};
                     p2s_pkg::REG_MODE:    out_latch = {6'd0, mode_setting};
                     p2s_pkg::REG_COUNT:   out_latch = {6'd0, byte_target};
                     default:              out_latch = '0;
                  endcase
               end
            end else if (t.strobe_req && !busy) begin
               // a strobe while a transfer runs is dropped
               tx_byte   = t.data_in;
               rx_ready  = 1'b0;
               rx_shift  = '0;
               bit_count = '0;
               busy      = 1'b1;
               sclk      = 1'b0;
               div_count = '0;
               spi_sel_n = 1'b0;
               mosi      = t.data_in[p2s_pkg::WORD_BITS-1];
            end
         end
         last_bus_clock = t.bus_clock;

         if (busy && spi_enabled) begin
            div_count = div_count + 4'd1;
            if (div_count >= clock_divider) begin
               div_count = '0;
               if (!sclk) begin
                  // rising SCLK: sample MISO
                  rx_shift = {rx_shift[p2s_pkg::WORD_BITS-2:0], t.miso_level};
                  sclk     = 1'b1;
               end else begin
                  bit_count = bit_count + 4'd1;
                  if (bit_count >= 4'(p2s_pkg::WORD_BITS)) begin
                     byte_count = byte_count + 2'd1;
                     if (byte_count >= byte_target) begin
                        // done: SCLK held high until the next idle tick
                        busy       = 1'b0;
                        rx_ready   = 1'b1;
                        out_latch  = rx_shift;
                        byte_count = '0;
                        bit_count  = '0;
                     end else begin
                        bit_count = '0;
                        mosi      = tx_byte[p2s_pkg::WORD_BITS-1];
                        sclk      = 1'b0;
                     end
                  end else begin
                     mosi = tx_byte[p2s_pkg::BIT_IDX_W'(p2s_pkg::WORD_BITS - 1)
                                    - bit_count[p2s_pkg::BIT_IDX_W-1:0]];
                     sclk = 1'b0;
                  end
               end
            end
         end else if (!busy && sclk) begin
            spi_sel_n = 1'b1;
            sclk      = 1'b0;
         end
      end
      want.data_out     = out_latch;
      want.sclk_level   = sclk;
      want.mosi_level   = mosi;
      want.spi_select_n = spi_sel_n;
      want.irq          = rx_ready & irq_enabled;
      expected_pins.push_back(want);
   endfunction

   function void compare_field(string name, logic [p2s_pkg::WORD_BITS-1:0] want,
                               logic [p2s_pkg::WORD_BITS-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   function void check_pins(p2s_pkg::rsp_payload_type got);
      p2s_pkg::rsp_payload_type want;
      if (expected_pins.size() == 0) begin
         $display("%0t: unexpected pin update, expected none actual %p", $time, got);
         mismatches++;
         return;
      end
      want = expected_pins.pop_front();
      compare_field("data_out", want.data_out, got.data_out);
      compare_field("sclk_level", 8'(want.sclk_level), 8'(got.sclk_level));
      compare_field("mosi_level", 8'(want.mosi_level), 8'(got.mosi_level));
      compare_field("spi_select_n", 8'(want.spi_select_n), 8'(got.spi_select_n));
      compare_field("irq", 8'(want.irq), 8'(got.irq));
   endfunction
endclass

module tb;
   localparam int TICK_TARGET    = 950;
   localparam int IDLE_PCT       = 8;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int SETTLE_CYCLES  = 10;
   localparam int FIRST_UNMAPPED = 4;
   localparam int LAST_ADDR      = 15;

   logic clock = 1'b0;
   logic reset;

   // free-running 50 MHz clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   p2s_req_if req_bus ();
   p2s_rsp_if rsp_bus ();

   parallel_to_spi_master_bridge_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   bridge_tracker tracker = new();
   int unsigned   ticks_sent;
   int unsigned   cycle_count;
   bit            quiet; // no idling on either side while set

   // Watchdog: a healthy run finishes far below this
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Result side: stall now and then, never while quiet
   always @(posedge clock) begin
      rsp_bus.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
   end

   // Monitor: both channels are sampled at the edge, before any of this
   // edge's updates land, so every transfer is seen exactly once.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            tracker.note_tick('{select_n:      req_bus.select_n,
                                bus_clock:     req_bus.bus_clock,
                                config_select: req_bus.config_select,
                                strobe_req:    req_bus.strobe_req,
                                data_in:       req_bus.data_in,
                                miso_level:    req_bus.miso_level});
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            tracker.check_pins('{data_out:     rsp_bus.data_out,
                                 sclk_level:   rsp_bus.sclk_level,
                                 mosi_level:   rsp_bus.mosi_level,
                                 spi_select_n: rsp_bus.spi_select_n,
                                 irq:          rsp_bus.irq});
         end
      end
   end

   function automatic logic rand_bit();
      return 1'($urandom_range(1));
   endfunction

   function automatic logic [p2s_pkg::WORD_BITS-1:0] rand_byte();
      return p2s_pkg::WORD_BITS'($urandom());
   endfunction

   // Build a tick; MISO is always random
   function automatic pin_sample_type pins(logic sel_n, logic clk, logic cfg, logic stb,
                                           logic [p2s_pkg::WORD_BITS-1:0] din);
      pin_sample_type t;
      t.select_n      = sel_n;
      t.bus_clock     = clk;
      t.config_select = cfg;
      t.strobe_req    = stb;
      t.data_in       = din;
      t.miso_level    = rand_bit();
      return t;
   endfunction

   // Offer one tick and hold it until the bridge takes the transfer
   task automatic drive_tick(pin_sample_type t);
      if (!quiet) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_bus.valid         <= 1'b1;
      req_bus.select_n      <= t.select_n;
      req_bus.bus_clock     <= t.bus_clock;
      req_bus.config_select <= t.config_select;
      req_bus.strobe_req    <= t.strobe_req;
      req_bus.data_in       <= t.data_in;
      req_bus.miso_level    <= t.miso_level;
      do @(posedge clock); while (!req_bus.ready);
      ticks_sent++;
   endtask

   // Host access: bus clock low with junk on the pins, then the rising edge
   task automatic host_access(logic cfg, logic stb, logic [p2s_pkg::WORD_BITS-1:0] din);
      drive_tick(pins(1'b0, 1'b0, rand_bit(), rand_bit(), rand_byte()));
      drive_tick(pins(1'b0, 1'b1, cfg, stb, din));
   endtask

   task automatic reg_write(logic [3:0] addr, logic [3:0] value);
      host_access(1'b1, 1'b1, {value, addr});
   endtask

   task automatic reg_read(logic [3:0] addr);
      host_access(1'b1, 1'b0, {4'($urandom_range(15)), addr});
   endtask

   // Selected, bus clock low: the serial engine just runs
   task automatic hold_ticks(int n);
      repeat (n) drive_tick(pins(1'b0, 1'b0, rand_bit(), rand_bit(), rand_byte()));
   endtask

   // Sender pause until the bridge has answered every tick; the first edge
   // lets the monitor note the last accepted tick before the count is read.
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [3:0] pick_addr();
      if ($urandom_range(99) < 85)
         return 4'($urandom_range(p2s_pkg::REG_COUNT, p2s_pkg::REG_CTRL));
      return 4'($urandom_range(LAST_ADDR, FIRST_UNMAPPED));
   endfunction

   // Keep the engine mostly enabled and the divider mostly small so that
   // transfers finish often; the slow extremes still come up now and then.
   function automatic logic [3:0] pick_value(logic [3:0] addr);
      logic [3:0] v;
      int         roll;
      v    = 4'($urandom_range(15));
      roll = $urandom_range(99);
      case (addr)
         p2s_pkg::REG_CTRL:    v[0] = (roll < 90);
         p2s_pkg::REG_DIVIDER: begin
            if (roll < 70)      v = 4'($urandom_range(2));
            else if (roll < 95) v = 4'($urandom_range(7, 3));
         end
         default: ;
      endcase
      return v;
   endfunction

   initial begin
      logic [3:0] addr;
      int         roll;

      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.select_n      <= 1'b1;
      req_bus.bus_clock     <= 1'b0;
      req_bus.config_select <= 1'b0;
      req_bus.strobe_req    <= 1'b0;
      req_bus.data_in       <= '0;
      req_bus.miso_level    <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset readback, register extremes, unmapped address,
      // then a transfer with a second start while it is busy.
      reg_read(p2s_pkg::REG_CTRL);
      reg_write(p2s_pkg::REG_DIVIDER, 4'hF);
      reg_read(p2s_pkg::REG_DIVIDER);
      reg_write(p2s_pkg::REG_DIVIDER, 4'h0);
      reg_write(p2s_pkg::REG_MODE, 4'h3);
      reg_read(p2s_pkg::REG_MODE);
      reg_write(4'(LAST_ADDR), 4'hF);
      reg_read(4'(LAST_ADDR));
      reg_write(p2s_pkg::REG_CTRL, 4'h3);
      reg_write(p2s_pkg::REG_COUNT, 4'h0);
      host_access(1'b0, 1'b1, 8'hA5);
      host_access(1'b0, 1'b1, 8'h5A);
      drive_tick(pins(1'b1, 1'b1, 1'b1, 1'b1, 8'hFF));

      // Random: mostly well-formed host accesses and transfers, some noise
      while (ticks_sent < TICK_TARGET) begin
         quiet = (ticks_sent >= 300 && ticks_sent < 450);
         if (ticks_sent >= 500 && ticks_sent < 510) drain();
         roll = $urandom_range(99);
         if (roll < 30) begin
            host_access(1'b0, 1'b1, rand_byte());
            hold_ticks($urandom_range(40));
         end else if (roll < 45) begin
            addr = pick_addr();
            reg_write(addr, pick_value(addr));
         end else if (roll < 60) begin
            reg_read(pick_addr());
         end else if (roll < 75) begin
            hold_ticks($urandom_range(20, 1));
         end else if (roll < 85) begin
            // deselected: only the bus clock level is tracked
            repeat ($urandom_range(4, 1))
               drive_tick(pins(1'b1, rand_bit(), rand_bit(), rand_bit(), rand_byte()));
         end else if (roll < 95) begin
            // edge taken while deselected, then selected with clock high:
            // no edge must be seen
            drive_tick(pins(1'b1, 1'b1, rand_bit(), rand_bit(), rand_byte()));
            drive_tick(pins(1'b0, 1'b1, rand_bit(), 1'b1, rand_byte()));
         end else begin
            drive_tick(pins(rand_bit(), rand_bit(), rand_bit(), rand_bit(), rand_byte()));
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
